// ----- hw/rtl/u2p_pkg.sv -----
// Shared types, sizes and the pinyin spelling table of the UTF-8 to pinyin block.
// Used by the front, the spelling queue, the back and the top level. No dependencies.
package u2p_pkg;

    // Longest spelling held in the table, in letters.
    localparam int MAX_LETTERS = 6;
    localparam int LEN_W       = $clog2(MAX_LETTERS + 1);
    localparam int IDX_W       = $clog2(MAX_LETTERS);
    localparam int CP_W        = 21;

    // Depth of the queue between the front and the back.
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    // One spelling: letter count and ASCII bytes, the first letter in the highest used byte.
    typedef struct packed {
        logic [LEN_W-1:0]                len;
        logic [MAX_LETTERS-1:0][7:0]     chars;
    } t_spell;

    // Queue write side, driven by the front.
    typedef struct packed {
        logic   vld;
        t_spell spell;
    } t_q_wr;

    // Queue head, seen by the back.
    typedef struct packed {
        logic   vld;
        t_spell spell;
    } t_q_head;

    // Spelling lookup by code point; a miss returns a zero length.
    function automatic t_spell pinyin_lookup(input logic [15:0] cp);
        t_spell r;
        r = '{len: '0, chars: '0};
        unique case (cp)
            16'h4E00: r = '{len: LEN_W'(2), chars: 48'("YI")};
            16'h4E09: r = '{len: LEN_W'(3), chars: 48'("SAN")};
            16'h4E1A: r = '{len: LEN_W'(2), chars: 48'("YE")};
            16'h4E2D: r = '{len: LEN_W'(5), chars: 48'("ZHONG")};
            16'h4E34: r = '{len: LEN_W'(3), chars: 48'("LIN")};
            16'h4E8B: r = '{len: LEN_W'(3), chars: 48'("SHI")};
            16'h4E8C: r = '{len: LEN_W'(2), chars: 48'("ER")};
            16'h4EA7: r = '{len: LEN_W'(4), chars: 48'("CHAN")};
            16'h4EBA: r = '{len: LEN_W'(3), chars: 48'("REN")};
            16'h4ECB: r = '{len: LEN_W'(3), chars: 48'("JIE")};
            16'h4F1A: r = '{len: LEN_W'(3), chars: 48'("HUI")};
            16'h4F20: r = '{len: LEN_W'(5), chars: 48'("CHUAN")};
            16'h4F4F: r = '{len: LEN_W'(3), chars: 48'("ZHU")};
            16'h4FDD: r = '{len: LEN_W'(3), chars: 48'("BAO")};
            16'h4FE1: r = '{len: LEN_W'(3), chars: 48'("XIN")};
            16'h4FEE: r = '{len: LEN_W'(3), chars: 48'("XIU")};
            16'h503C: r = '{len: LEN_W'(3), chars: 48'("ZHI")};
            16'h5065: r = '{len: LEN_W'(4), chars: 48'("JIAN")};
            16'h513F: r = '{len: LEN_W'(2), chars: 48'("ER")};
            16'h514D: r = '{len: LEN_W'(4), chars: 48'("MIAN")};
            16'h5165: r = '{len: LEN_W'(2), chars: 48'("RU")};
            16'h5168: r = '{len: LEN_W'(4), chars: 48'("QUAN")};
            16'h5185: r = '{len: LEN_W'(3), chars: 48'("NEI")};
            16'h5206: r = '{len: LEN_W'(3), chars: 48'("FEN")};
            16'h529E: r = '{len: LEN_W'(3), chars: 48'("BAN")};
            16'h52A1: r = '{len: LEN_W'(2), chars: 48'("WU")};
            16'h52E4: r = '{len: LEN_W'(3), chars: 48'("QIN")};
            16'h5316: r = '{len: LEN_W'(3), chars: 48'("HUA")};
            16'h533A: r = '{len: LEN_W'(2), chars: 48'("QU")};
            16'h533B: r = '{len: LEN_W'(2), chars: 48'("YI")};
            16'h536B: r = '{len: LEN_W'(3), chars: 48'("WEI")};
            16'h53D1: r = '{len: LEN_W'(2), chars: 48'("FA")};
            16'h53D6: r = '{len: LEN_W'(2), chars: 48'("QU")};
            16'h53E3: r = '{len: LEN_W'(3), chars: 48'("KOU")};
            16'h53F0: r = '{len: LEN_W'(3), chars: 48'("TAI")};
            16'h53F7: r = '{len: LEN_W'(3), chars: 48'("HAO")};
            16'h540E: r = '{len: LEN_W'(3), chars: 48'("HOU")};
            16'h5411: r = '{len: LEN_W'(5), chars: 48'("XIANG")};
            16'h5438: r = '{len: LEN_W'(2), chars: 48'("XI")};
            16'h547C: r = '{len: LEN_W'(2), chars: 48'("HU")};
            16'h5589: r = '{len: LEN_W'(3), chars: 48'("HOU")};
            16'h578B: r = '{len: LEN_W'(4), chars: 48'("XING")};
            16'h57DF: r = '{len: LEN_W'(2), chars: 48'("YU")};
            16'h58EB: r = '{len: LEN_W'(3), chars: 48'("SHI")};
            16'h5907: r = '{len: LEN_W'(3), chars: 48'("BEI")};
            16'h590D: r = '{len: LEN_W'(2), chars: 48'("FU")};
            16'h5916: r = '{len: LEN_W'(3), chars: 48'("WAI")};
            16'h5987: r = '{len: LEN_W'(2), chars: 48'("FU")};
            16'h59E8: r = '{len: LEN_W'(2), chars: 48'("YI")};
            16'h5B66: r = '{len: LEN_W'(3), chars: 48'("XUE")};
            16'h5B9E: r = '{len: LEN_W'(3), chars: 48'("SHI")};
            16'h5BA3: r = '{len: LEN_W'(4), chars: 48'("XUAN")};
            16'h5BA4: r = '{len: LEN_W'(3), chars: 48'("SHI")};
            16'h5BFC: r = '{len: LEN_W'(3), chars: 48'("DAO")};
            16'h5C04: r = '{len: LEN_W'(3), chars: 48'("SHE")};
            16'h5C3F: r = '{len: LEN_W'(4), chars: 48'("NIAO")};
            16'h5DE5: r = '{len: LEN_W'(4), chars: 48'("GONG")};
            16'h5E8A: r = '{len: LEN_W'(6), chars: 48'("CHUANG")};
            16'h5E93: r = '{len: LEN_W'(2), chars: 48'("KU")};
            16'h5EB7: r = '{len: LEN_W'(4), chars: 48'("KANG")};
            16'h5ECA: r = '{len: LEN_W'(4), chars: 48'("LANG")};
            16'h5F0F: r = '{len: LEN_W'(3), chars: 48'("SHI")};
            16'h5FAE: r = '{len: LEN_W'(3), chars: 48'("WEI")};
            16'h5FC3: r = '{len: LEN_W'(3), chars: 48'("XIN")};
            16'h6025: r = '{len: LEN_W'(2), chars: 48'("JI")};
            16'h603B: r = '{len: LEN_W'(4), chars: 48'("ZONG")};
            16'h606F: r = '{len: LEN_W'(2), chars: 48'("XI")};
            16'h611F: r = '{len: LEN_W'(3), chars: 48'("GAN")};
            16'h623F: r = '{len: LEN_W'(4), chars: 48'("FANG")};
            16'h624B: r = '{len: LEN_W'(4), chars: 48'("SHOU")};
            16'h6280: r = '{len: LEN_W'(2), chars: 48'("JI")};
            16'h62A2: r = '{len: LEN_W'(5), chars: 48'("QIANG")};
            16'h62A4: r = '{len: LEN_W'(2), chars: 48'("HU")};
            16'h6301: r = '{len: LEN_W'(3), chars: 48'("CHI")};
            16'h6302: r = '{len: LEN_W'(3), chars: 48'("GUA")};
            16'h63A7: r = '{len: LEN_W'(4), chars: 48'("KONG")};
            16'h652F: r = '{len: LEN_W'(3), chars: 48'("ZHI")};
            16'h6536: r = '{len: LEN_W'(4), chars: 48'("SHOU")};
            16'h6551: r = '{len: LEN_W'(3), chars: 48'("JIU")};
            16'h6559: r = '{len: LEN_W'(4), chars: 48'("JIAO")};
            16'h65B0: r = '{len: LEN_W'(3), chars: 48'("XIN")};
            16'h666E: r = '{len: LEN_W'(2), chars: 48'("PU")};
            16'h672C: r = '{len: LEN_W'(3), chars: 48'("BEN")};
            16'h672F: r = '{len: LEN_W'(3), chars: 48'("SHU")};
            16'h6768: r = '{len: LEN_W'(4), chars: 48'("YANG")};
            16'h6807: r = '{len: LEN_W'(4), chars: 48'("BIAO")};
            16'h6838: r = '{len: LEN_W'(2), chars: 48'("HE")};
            16'h68C0: r = '{len: LEN_W'(4), chars: 48'("JIAN")};
            16'h697C: r = '{len: LEN_W'(3), chars: 48'("LOU")};
            16'h6B8A: r = '{len: LEN_W'(3), chars: 48'("SHU")};
            16'h6CCC: r = '{len: LEN_W'(2), chars: 48'("MI")};
            16'h6CE8: r = '{len: LEN_W'(3), chars: 48'("ZHU")};
            16'h6D88: r = '{len: LEN_W'(4), chars: 48'("XIAO")};
            16'h6DB2: r = '{len: LEN_W'(2), chars: 48'("YE")};
            16'h70ED: r = '{len: LEN_W'(2), chars: 48'("RE")};
            16'h7269: r = '{len: LEN_W'(2), chars: 48'("WU")};
            16'h7279: r = '{len: LEN_W'(2), chars: 48'("TE")};
            16'h73ED: r = '{len: LEN_W'(3), chars: 48'("BAN")};
            16'h751F: r = '{len: LEN_W'(5), chars: 48'("SHENG")};
            16'h7535: r = '{len: LEN_W'(4), chars: 48'("DIAN")};
            16'h75AB: r = '{len: LEN_W'(2), chars: 48'("YI")};
            16'h75BE: r = '{len: LEN_W'(2), chars: 48'("JI")};
            16'h75C5: r = '{len: LEN_W'(4), chars: 48'("BING")};
            16'h7624: r = '{len: LEN_W'(3), chars: 48'("LIU")};
            16'h76AE: r = '{len: LEN_W'(2), chars: 48'("PI")};
            16'h773C: r = '{len: LEN_W'(3), chars: 48'("YAN")};
            16'h795E: r = '{len: LEN_W'(4), chars: 48'("SHEN")};
            16'h79D1: r = '{len: LEN_W'(2), chars: 48'("KE")};
            16'h7AD9: r = '{len: LEN_W'(4), chars: 48'("ZHAN")};
            16'h7BA1: r = '{len: LEN_W'(4), chars: 48'("GUAN")};
            16'h7EBF: r = '{len: LEN_W'(4), chars: 48'("XIAN")};
            16'h7ECF: r = '{len: LEN_W'(4), chars: 48'("JING")};
            16'h7EF4: r = '{len: LEN_W'(3), chars: 48'("WEI")};
            16'h8033: r = '{len: LEN_W'(2), chars: 48'("ER")};
            16'h809D: r = '{len: LEN_W'(3), chars: 48'("GAN")};
            16'h80A0: r = '{len: LEN_W'(5), chars: 48'("CHANG")};
            16'h80A4: r = '{len: LEN_W'(2), chars: 48'("FU")};
            16'h80BE: r = '{len: LEN_W'(4), chars: 48'("SHEN")};
            16'h80BF: r = '{len: LEN_W'(5), chars: 48'("ZHONG")};
            16'h8154: r = '{len: LEN_W'(5), chars: 48'("QIANG")};
            16'h836F: r = '{len: LEN_W'(3), chars: 48'("YAO")};
            16'h8840: r = '{len: LEN_W'(3), chars: 48'("XUE")};
            16'h897F: r = '{len: LEN_W'(2), chars: 48'("XI")};
            16'h8BBE: r = '{len: LEN_W'(3), chars: 48'("SHE")};
            16'h8BCA: r = '{len: LEN_W'(4), chars: 48'("ZHEN")};
            16'h8BDD: r = '{len: LEN_W'(3), chars: 48'("HUA")};
            16'h8D39: r = '{len: LEN_W'(3), chars: 48'("FEI")};
            16'h8D70: r = '{len: LEN_W'(3), chars: 48'("ZOU")};
            16'h9001: r = '{len: LEN_W'(4), chars: 48'("SONG")};
            16'h900F: r = '{len: LEN_W'(3), chars: 48'("TOU")};
            16'h9053: r = '{len: LEN_W'(3), chars: 48'("DAO")};
            16'h914D: r = '{len: LEN_W'(3), chars: 48'("PEI")};
            16'h91D1: r = '{len: LEN_W'(3), chars: 48'("JIN")};
            16'h95E8: r = '{len: LEN_W'(3), chars: 48'("MEN")};
            16'h9632: r = '{len: LEN_W'(4), chars: 48'("FANG")};
            16'h963F: r = '{len: LEN_W'(1), chars: 48'("A")};
            16'h9662: r = '{len: LEN_W'(4), chars: 48'("YUAN")};
            16'h9884: r = '{len: LEN_W'(2), chars: 48'("YU")};
            16'h9A8C: r = '{len: LEN_W'(3), chars: 48'("YAN")};
            16'h9AA8: r = '{len: LEN_W'(2), chars: 48'("GU")};
            16'h9F3B: r = '{len: LEN_W'(2), chars: 48'("BI")};
            default:  r = '{len: '0, chars: '0};
        endcase
        return r;
    endfunction

endpackage

// ----- hw/rtl/utf8_to_pinyin_letters.sv -----
// Top level of the UTF-8 to pinyin letter converter.
// Depends on u2p_pkg, u2p_front, u2p_queue and u2p_back.
//
// Usage:
//   The slave stream takes UTF-8 text, one byte a beat; tlast marks the final byte of a
//   text, after which an unfinished sequence is dropped. The master stream gives one
//   uppercase ASCII letter a beat for each decoded Chinese character found in the
//   spelling table; tlast marks the final letter of that character. ASCII, misses and
//   malformed bytes give no beats.
//   i_cfg_we writes i_cfg_wdata into the mode bit: 1 gives only the initial letter,
//   0 the full spelling. Write it only while no text is in flight.
//   The completing byte passes the front stage register and the queue; the first
//   letter is valid once it is loaded into the output register.
//   Throughput: one input byte a cycle unless stalled, one output letter a cycle while the
//   receiver is ready; each letter is a beat, so long spellings set the sustained rate.
//   A four-entry queue of spellings sits between decoder and letter walker; the input
//   stalls only when that queue is full and a hit is waiting to enter it.
//   When the receiver stalls, the output register holds its beat and the queue fills.
//   Reset (synchronous, active low) clears the decoder, the queue, the output and the
//   mode bit (full spelling).
module utf8_to_pinyin_letters (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] text_byte
    input  logic       s_axis_tlast,   // end_of_text
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [6:0] letter, [7] zero
    output logic       m_axis_tlast    // last_of_character
);
    import u2p_pkg::*;

    logic    r_initials_mode;
    t_q_wr   q_wr;
    t_q_head q_head;
    logic    q_full;
    logic    q_pop;
    logic [6:0] letter;

    // Mode register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_initials_mode <= 1'b0;
        end else if (i_cfg_we) begin
            r_initials_mode <= i_cfg_wdata;
        end
    end

    u2p_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_byte  (s_axis_tdata),
        .i_eot   (s_axis_tlast),
        .o_wr    (q_wr),
        .i_full  (q_full)
    );

    u2p_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .o_full  (q_full),
        .o_head  (q_head),
        .i_pop   (q_pop)
    );

    u2p_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (q_head),
        .o_pop      (q_pop),
        .i_initials (r_initials_mode),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_letter   (letter),
        .o_last     (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, letter};

endmodule

// ----- hw/rtl/u2p_front.sv -----
// Front of the UTF-8 to pinyin block: decodes bytes into code points and looks them up.
// Depends on u2p_pkg for the spelling table and the queue write type.
module u2p_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [7:0]     i_byte,
    input  logic           i_eot,
    output u2p_pkg::t_q_wr o_wr,
    input  logic           i_full
);
    import u2p_pkg::*;

    logic [CP_W-1:0] r_acc, n_acc;
    logic [1:0]      r_exp, n_exp;
    logic            r_cp_vld, n_cp_vld;
    logic [CP_W-1:0] r_cp, n_cp;

    logic            accept;
    logic            advance;
    logic            done;
    logic [CP_W-1:0] acc_dec;
    t_spell          lk;
    logic            hit;

    // Lookup of the completed code point held in the stage register.
    always_comb begin
        lk  = pinyin_lookup(r_cp[15:0]);
        hit = (r_cp[CP_W-1:16] == '0) && (lk.len != '0);
    end

    // The stage moves on when empty, when its code point misses, or when the queue has room.
    assign advance = !r_cp_vld || !hit || !i_full;
    assign o_ready = advance;
    assign accept  = i_valid && advance;

    assign o_wr.vld   = r_cp_vld && hit && !i_full;
    assign o_wr.spell = lk;

    // Sequence decoder: continuation bytes extend an open code point, others start over.
    always_comb begin
        n_exp   = r_exp;
        acc_dec = r_acc;
        done    = 1'b0;
        if ((r_exp != 2'd0) && (i_byte[7:6] == 2'b10)) begin
            acc_dec = {r_acc[CP_W-7:0], i_byte[5:0]};
            n_exp   = r_exp - 2'd1;
            done    = (r_exp == 2'd1);
        end else begin
            n_exp = 2'd0;
            priority if (i_byte[7] == 1'b0) begin
                acc_dec = CP_W'(i_byte);
            end else if (i_byte[7:5] == 3'b110) begin
                acc_dec = CP_W'(i_byte[4:0]);
                n_exp   = 2'd1;
            end else if (i_byte[7:4] == 4'b1110) begin
                acc_dec = CP_W'(i_byte[3:0]);
                n_exp   = 2'd2;
            end else if (i_byte[7:3] == 5'b11110) begin
                acc_dec = CP_W'(i_byte[2:0]);
                n_exp   = 2'd3;
            end else begin
                acc_dec = r_acc;
            end
        end
        n_acc = acc_dec;
        // End of text drops whatever sequence is still open.
        if (i_eot) begin
            n_exp = 2'd0;
            n_acc = '0;
        end
    end

    // Stage register update.
    always_comb begin
        n_cp_vld = r_cp_vld;
        n_cp     = r_cp;
        if (advance) begin
            n_cp_vld = accept && done;
            n_cp     = acc_dec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc    <= '0;
            r_exp    <= 2'd0;
            r_cp_vld <= 1'b0;
        end else begin
            if (accept) begin
                r_acc <= n_acc;
                r_exp <= n_exp;
            end
            r_cp_vld <= n_cp_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cp <= n_cp;
    end

endmodule

// ----- hw/rtl/u2p_queue.sv -----
// Short queue of spellings between the front and the back of the UTF-8 to pinyin block.
// Depends on u2p_pkg for the entry type and the depth.
module u2p_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  u2p_pkg::t_q_wr   i_wr,
    output logic             o_full,
    output u2p_pkg::t_q_head o_head,
    input  logic             i_pop
);
    import u2p_pkg::*;

    t_spell           r_mem [QDEPTH];
    logic [QAW-1:0]   r_wp, r_rp;
    logic [QCW-1:0]   r_cnt;
    logic             wr_en;
    logic             rd_en;

    assign o_full       = (r_cnt == QCW'(QDEPTH));
    assign wr_en        = i_wr.vld && !o_full;
    assign rd_en        = i_pop && (r_cnt != '0);
    assign o_head.vld   = (r_cnt != '0);
    assign o_head.spell = r_mem[r_rp];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) begin
                r_wp <= r_wp + QAW'(1);
            end
            if (rd_en) begin
                r_rp <= r_rp + QAW'(1);
            end
            r_cnt <= r_cnt + QCW'(wr_en) - QCW'(rd_en);
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wp] <= i_wr.spell;
        end
    end

endmodule

// ----- hw/rtl/u2p_back.sv -----
// Back of the UTF-8 to pinyin block: walks the spelling at the queue head, one letter a beat.
// Depends on u2p_pkg for the queue head type and letter sizes.
module u2p_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  u2p_pkg::t_q_head i_head,
    output logic             o_pop,
    input  logic             i_initials,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [6:0]       o_letter,
    output logic             o_last
);
    import u2p_pkg::*;

    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_vld;
    logic [6:0]       r_letter;
    logic             r_last;

    logic             out_free;
    logic             load;
    logic             is_last;
    logic [IDX_W-1:0] pos;

    // The first letter sits in the highest used byte of the spelling.
    assign pos     = IDX_W'(i_head.spell.len - LEN_W'(1) - LEN_W'(r_idx));
    assign is_last = i_initials || (LEN_W'(r_idx) == i_head.spell.len - LEN_W'(1));

    assign out_free = !r_vld || i_ready;
    assign load     = out_free && i_head.vld;
    assign o_pop    = load && is_last;

    always_comb begin
        n_idx = r_idx;
        if (load) begin
            n_idx = is_last ? '0 : r_idx + IDX_W'(1);
        end
    end

    // Output register; takes the next letter whenever the receiver has taken the last one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            r_idx <= '0;
        end else begin
            if (out_free) begin
                r_vld <= i_head.vld;
            end
            r_idx <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_letter <= i_head.spell.chars[pos][6:0];
            r_last   <= is_last;
        end
    end

    assign o_valid  = r_vld;
    assign o_letter = r_letter;
    assign o_last   = r_last;

    // The letter position never runs past the spelling at the head.
    a_idx_in_spell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_head.vld |-> (LEN_W'(r_idx) < i_head.spell.len))
        else $error("letter position beyond spelling length");

    // Every letter shown is an uppercase ASCII letter.
    a_letter_upper: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld |-> ((r_letter >= 7'd65) && (r_letter <= 7'd90)))
        else $error("output letter outside A to Z");

    // Retiring a spelling goes with a marked final letter in the output register.
    a_pop_marks_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_vld && r_last))
        else $error("spelling retired without a marked final letter");

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench of utf8_to_pinyin_letters: UTF-8 text in, pinyin letters out.
// Depends on u2p_pkg (MAX_LETTERS) and on the RTL of the block; it reads no files.
`timescale 1ns / 1ps

module tb_top;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } t_text_beat;

    typedef struct packed {
        logic [6:0] letter;
        logic       last_of_char;
    } t_pinyin_letter;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic       i_cfg_wdata = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;   // [7:0] text_byte
    logic       s_axis_tlast = 1'b0;    // end_of_text
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;           // [6:0] letter, [7] zero
    logic       m_axis_tlast;           // last_of_character

    // Text bytes waiting for the driver and letters waiting for the monitor.
    t_text_beat     text_q[$];
    t_pinyin_letter letters_q[$];
    t_text_beat     next_beat;
    t_pinyin_letter want;

    // Beats presented by the driver and beats taken by the block.
    int tx_sent = 0;
    int tx_accepted = 0;

    // Idle percentages of sender and receiver.
    int tx_idle_pct = 9;
    int rx_idle_pct = 66;
    int fail_count = 0;
    int cycle_cnt = 0;

    // Decoder state as the block should hold it.
    logic [20:0] cp_acc = '0;
    logic [1:0]  cont_left = '0;
    logic        initials_mode = 1'b0;

    utf8_to_pinyin_letters u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Spelling table, entry by entry: code point and uppercase pinyin.
    task automatic rom_at(input int idx, output logic [15:0] c, output string s);
        case (idx)
            0: begin c = 16'h4E00; s = "YI"; end      1: begin c = 16'h4E09; s = "SAN"; end
            2: begin c = 16'h4E1A; s = "YE"; end      3: begin c = 16'h4E2D; s = "ZHONG"; end
            4: begin c = 16'h4E34; s = "LIN"; end     5: begin c = 16'h4E8B; s = "SHI"; end
            6: begin c = 16'h4E8C; s = "ER"; end      7: begin c = 16'h4EA7; s = "CHAN"; end
            8: begin c = 16'h4EBA; s = "REN"; end     9: begin c = 16'h4ECB; s = "JIE"; end
            10: begin c = 16'h4F1A; s = "HUI"; end    11: begin c = 16'h4F20; s = "CHUAN"; end
            12: begin c = 16'h4F4F; s = "ZHU"; end    13: begin c = 16'h4FDD; s = "BAO"; end
            14: begin c = 16'h4FE1; s = "XIN"; end    15: begin c = 16'h4FEE; s = "XIU"; end
            16: begin c = 16'h503C; s = "ZHI"; end    17: begin c = 16'h5065; s = "JIAN"; end
            18: begin c = 16'h513F; s = "ER"; end     19: begin c = 16'h514D; s = "MIAN"; end
            20: begin c = 16'h5165; s = "RU"; end     21: begin c = 16'h5168; s = "QUAN"; end
            22: begin c = 16'h5185; s = "NEI"; end    23: begin c = 16'h5206; s = "FEN"; end
            24: begin c = 16'h529E; s = "BAN"; end    25: begin c = 16'h52A1; s = "WU"; end
            26: begin c = 16'h52E4; s = "QIN"; end    27: begin c = 16'h5316; s = "HUA"; end
            28: begin c = 16'h533A; s = "QU"; end     29: begin c = 16'h533B; s = "YI"; end
            30: begin c = 16'h536B; s = "WEI"; end    31: begin c = 16'h53D1; s = "FA"; end
            32: begin c = 16'h53D6; s = "QU"; end     33: begin c = 16'h53E3; s = "KOU"; end
            34: begin c = 16'h53F0; s = "TAI"; end    35: begin c = 16'h53F7; s = "HAO"; end
            36: begin c = 16'h540E; s = "HOU"; end    37: begin c = 16'h5411; s = "XIANG"; end
            38: begin c = 16'h5438; s = "XI"; end     39: begin c = 16'h547C; s = "HU"; end
            40: begin c = 16'h5589; s = "HOU"; end    41: begin c = 16'h578B; s = "XING"; end
            42: begin c = 16'h57DF; s = "YU"; end     43: begin c = 16'h58EB; s = "SHI"; end
            44: begin c = 16'h5907; s = "BEI"; end    45: begin c = 16'h590D; s = "FU"; end
            46: begin c = 16'h5916; s = "WAI"; end    47: begin c = 16'h5987; s = "FU"; end
            48: begin c = 16'h59E8; s = "YI"; end     49: begin c = 16'h5B66; s = "XUE"; end
            50: begin c = 16'h5B9E; s = "SHI"; end    51: begin c = 16'h5BA3; s = "XUAN"; end
            52: begin c = 16'h5BA4; s = "SHI"; end    53: begin c = 16'h5BFC; s = "DAO"; end
            54: begin c = 16'h5C04; s = "SHE"; end    55: begin c = 16'h5C3F; s = "NIAO"; end
            56: begin c = 16'h5DE5; s = "GONG"; end   57: begin c = 16'h5E8A; s = "CHUANG"; end
            58: begin c = 16'h5E93; s = "KU"; end     59: begin c = 16'h5EB7; s = "KANG"; end
            60: begin c = 16'h5ECA; s = "LANG"; end   61: begin c = 16'h5F0F; s = "SHI"; end
            62: begin c = 16'h5FAE; s = "WEI"; end    63: begin c = 16'h5FC3; s = "XIN"; end
            64: begin c = 16'h6025; s = "JI"; end     65: begin c = 16'h603B; s = "ZONG"; end
            66: begin c = 16'h606F; s = "XI"; end     67: begin c = 16'h611F; s = "GAN"; end
            68: begin c = 16'h623F; s = "FANG"; end   69: begin c = 16'h624B; s = "SHOU"; end
            70: begin c = 16'h6280; s = "JI"; end     71: begin c = 16'h62A2; s = "QIANG"; end
            72: begin c = 16'h62A4; s = "HU"; end     73: begin c = 16'h6301; s = "CHI"; end
            74: begin c = 16'h6302; s = "GUA"; end    75: begin c = 16'h63A7; s = "KONG"; end
            76: begin c = 16'h652F; s = "ZHI"; end    77: begin c = 16'h6536; s = "SHOU"; end
            78: begin c = 16'h6551; s = "JIU"; end    79: begin c = 16'h6559; s = "JIAO"; end
            80: begin c = 16'h65B0; s = "XIN"; end    81: begin c = 16'h666E; s = "PU"; end
            82: begin c = 16'h672C; s = "BEN"; end    83: begin c = 16'h672F; s = "SHU"; end
            84: begin c = 16'h6768; s = "YANG"; end   85: begin c = 16'h6807; s = "BIAO"; end
            86: begin c = 16'h6838; s = "HE"; end     87: begin c = 16'h68C0; s = "JIAN"; end
            88: begin c = 16'h697C; s = "LOU"; end    89: begin c = 16'h6B8A; s = "SHU"; end
            90: begin c = 16'h6CCC; s = "MI"; end     91: begin c = 16'h6CE8; s = "ZHU"; end
            92: begin c = 16'h6D88; s = "XIAO"; end   93: begin c = 16'h6DB2; s = "YE"; end
            94: begin c = 16'h70ED; s = "RE"; end     95: begin c = 16'h7269; s = "WU"; end
            96: begin c = 16'h7279; s = "TE"; end     97: begin c = 16'h73ED; s = "BAN"; end
            98: begin c = 16'h751F; s = "SHENG"; end  99: begin c = 16'h7535; s = "DIAN"; end
            100: begin c = 16'h75AB; s = "YI"; end    101: begin c = 16'h75BE; s = "JI"; end
            102: begin c = 16'h75C5; s = "BING"; end  103: begin c = 16'h7624; s = "LIU"; end
            104: begin c = 16'h76AE; s = "PI"; end    105: begin c = 16'h773C; s = "YAN"; end
            106: begin c = 16'h795E; s = "SHEN"; end  107: begin c = 16'h79D1; s = "KE"; end
            108: begin c = 16'h7AD9; s = "ZHAN"; end  109: begin c = 16'h7BA1; s = "GUAN"; end
            110: begin c = 16'h7EBF; s = "XIAN"; end  111: begin c = 16'h7ECF; s = "JING"; end
            112: begin c = 16'h7EF4; s = "WEI"; end   113: begin c = 16'h8033; s = "ER"; end
            114: begin c = 16'h809D; s = "GAN"; end   115: begin c = 16'h80A0; s = "CHANG"; end
            116: begin c = 16'h80A4; s = "FU"; end    117: begin c = 16'h80BE; s = "SHEN"; end
            118: begin c = 16'h80BF; s = "ZHONG"; end 119: begin c = 16'h8154; s = "QIANG"; end
            120: begin c = 16'h836F; s = "YAO"; end   121: begin c = 16'h8840; s = "XUE"; end
            122: begin c = 16'h897F; s = "XI"; end    123: begin c = 16'h8BBE; s = "SHE"; end
            124: begin c = 16'h8BCA; s = "ZHEN"; end  125: begin c = 16'h8BDD; s = "HUA"; end
            126: begin c = 16'h8D39; s = "FEI"; end   127: begin c = 16'h8D70; s = "ZOU"; end
            128: begin c = 16'h9001; s = "SONG"; end  129: begin c = 16'h900F; s = "TOU"; end
            130: begin c = 16'h9053; s = "DAO"; end   131: begin c = 16'h914D; s = "PEI"; end
            132: begin c = 16'h91D1; s = "JIN"; end   133: begin c = 16'h95E8; s = "MEN"; end
            134: begin c = 16'h9632; s = "FANG"; end  135: begin c = 16'h963F; s = "A"; end
            136: begin c = 16'h9662; s = "YUAN"; end  137: begin c = 16'h9884; s = "YU"; end
            138: begin c = 16'h9A8C; s = "YAN"; end   139: begin c = 16'h9AA8; s = "GU"; end
            default: begin c = 16'h9F3B; s = "BI"; end
        endcase
    endtask

    // Queue the letters that one completed code point should produce.
    task automatic expect_letters(input logic [20:0] cp);
        logic [15:0]    c;
        string          s;
        int             n;
        byte            ch;
        logic           found;
        t_pinyin_letter item;
        found = 1'b0;
        if (cp > 21'h7F) begin
            for (int i = 0; i < 150 && !found; i++) begin
                rom_at(i, c, s);
                if ({5'd0, c} == cp) begin
                    found = 1'b1;
                    n = s.len();
                    if (n > u2p_pkg::MAX_LETTERS) n = u2p_pkg::MAX_LETTERS;
                    if (initials_mode) n = 1;
                    for (int k = 0; k < n; k++) begin
                        ch = s[k];
                        item.letter = ch[6:0];
                        item.last_of_char = (k == n - 1);
                        letters_q.insert(letters_q.size(), item);
                    end
                end
            end
        end
    endtask

    // Advance the decoder by one accepted text byte.
    task automatic decode_text_byte(input logic [7:0] b, input logic eot);
        if (cont_left != 2'd0 && b[7:6] == 2'b10) begin
            cp_acc = {cp_acc[14:0], b[5:0]};
            cont_left = cont_left - 2'd1;
            if (cont_left == 2'd0) expect_letters(cp_acc);
        end else begin
            // A stray byte also lands here and leaves the decoder idle.
            cont_left = 2'd0;
            if (!b[7]) begin
                cp_acc = {13'd0, b};
            end else if (b[7:5] == 3'b110) begin
                cp_acc = {16'd0, b[4:0]};
                cont_left = 2'd1;
            end else if (b[7:4] == 4'b1110) begin
                cp_acc = {17'd0, b[3:0]};
                cont_left = 2'd2;
            end else if (b[7:3] == 5'b11110) begin
                cp_acc = {18'd0, b[2:0]};
                cont_left = 2'd3;
            end
        end
        if (eot) begin
            cont_left = 2'd0;
            cp_acc = '0;
        end
    endtask

    task automatic put_byte(input logic [7:0] b, input logic eot);
        t_text_beat beat;
        beat.text_byte = b;
        beat.end_of_text = eot;
        text_q.insert(text_q.size(), beat);
    endtask

    // Queue the first keep bytes of the UTF-8 encoding of cp; eot goes on the last one queued.
    task automatic put_seq(input logic [20:0] cp, input int nbytes, input int keep,
                           input logic eot);
        logic [7:0] enc [4];
        case (nbytes)
            2: begin
                enc[0] = {3'b110, cp[10:6]};
                enc[1] = {2'b10, cp[5:0]};
            end
            3: begin
                enc[0] = {4'b1110, cp[15:12]};
                enc[1] = {2'b10, cp[11:6]};
                enc[2] = {2'b10, cp[5:0]};
            end
            default: begin
                enc[0] = {5'b11110, cp[20:18]};
                enc[1] = {2'b10, cp[17:12]};
                enc[2] = {2'b10, cp[11:6]};
                enc[3] = {2'b10, cp[5:0]};
            end
        endcase
        for (int k = 0; k < keep; k++) put_byte(enc[k], eot && (k == keep - 1));
    endtask

    // Wait until every byte is taken and every letter has come, then let the pipe settle.
    task automatic wait_drained();
        while (text_q.size() != 0 || s_axis_tvalid || letters_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic v);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        initials_mode = v;
    endtask

    // Random text: mostly well-formed characters, some broken or cut sequences and noise.
    task automatic queue_random_text(input int target);
        int          counted;
        int          r;
        int          keep;
        logic [15:0] c;
        string       s;
        logic [20:0] cp;
        logic        eot;
        counted = 0;
        while (counted < target) begin
            r = $urandom_range(99);
            eot = ($urandom_range(99) < 6);
            rom_at($urandom_range(149), c, s);
            if (r < 40) begin
                put_seq({5'd0, c}, 3, 3, eot);
                counted += 3;
            end else if (r < 50) begin
                cp = 21'($urandom_range(16'h4E00, 16'h9FFF));
                put_seq(cp, 3, 3, eot);
                counted += 3;
            end else if (r < 58) begin
                cp = 21'($urandom_range(11'h080, 11'h7FF));
                put_seq(cp, 2, 2, eot);
                counted += 2;
            end else if (r < 66) begin
                // Four-byte code points, half of them sharing the low bits of a table entry.
                if ($urandom_range(1)) cp = {5'($urandom_range(1, 31)), c};
                else cp = 21'($urandom_range(21'h1FFFFF));
                put_seq(cp, 4, 4, eot);
                counted += 4;
            end else if (r < 76) begin
                put_byte(8'($urandom_range(8'h7F)), eot);
                counted += 1;
            end else if (r < 84) begin
                keep = $urandom_range(1, 2);
                put_seq({5'd0, c}, 3, keep, 1'b0);
                counted += keep;
            end else if (r < 92) begin
                keep = $urandom_range(1, 2);
                put_seq({5'd0, c}, 3, keep, 1'b1);
                counted += keep;
            end else begin
                put_byte(8'($urandom_range(255)), eot);
            end
        end
        // Close the text so that nothing is in flight at the next mode write.
        put_byte(8'h2E, 1'b1);
    endtask

    // Sender: present the next byte once the current beat is taken.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!s_axis_tvalid || tx_accepted == tx_sent) begin
                if (text_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    next_beat = text_q.pop_front();
                    s_axis_tdata <= next_beat.text_byte;
                    s_axis_tlast <= next_beat.end_of_text;
                    s_axis_tvalid <= 1'b1;
                    tx_sent++;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random back-pressure.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Monitor: predict on every input beat and check every letter beat.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                decode_text_byte(s_axis_tdata, s_axis_tlast);
                tx_accepted++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (letters_q.size() == 0) begin
                    $error("letter beat 0x%02h with no letter expected", m_axis_tdata);
                    fail_count++;
                end else begin
                    want = letters_q.pop_front();
                    if (m_axis_tdata[6:0] !== want.letter) begin
                        $error("letter: expected 0x%02h, got 0x%02h",
                               want.letter, m_axis_tdata[6:0]);
                        fail_count++;
                    end
                    if (m_axis_tdata[7] !== 1'b0) begin
                        $error("tdata pad bit: expected 0, got %b", m_axis_tdata[7]);
                        fail_count++;
                    end
                    if (m_axis_tlast !== want.last_of_char) begin
                        $error("last_of_character: expected %b, got %b",
                               want.last_of_char, m_axis_tlast);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        write_mode(1'b0);

        // Directed text in full-spelling mode.
        put_byte(8'h41, 1'b0);                      // ASCII gives nothing
        put_byte(8'h00, 1'b0);
        put_seq(21'h4E00, 3, 3, 1'b0);              // YI
        put_seq(21'h5E8A, 3, 3, 1'b0);              // longest spelling, six letters
        put_seq(21'h00E9, 2, 2, 1'b0);              // two-byte miss
        put_byte(8'h80, 1'b0);                      // continuation while idle
        put_byte(8'hFF, 1'b0);                      // never a valid byte
        put_seq(21'h4E00, 3, 1, 1'b0);              // cut short by ASCII
        put_byte(8'h41, 1'b0);
        put_seq(21'h4E00, 3, 1, 1'b0);              // cut short by a new lead
        put_seq(21'h963F, 3, 3, 1'b0);              // one-letter spelling
        put_seq(21'h4E00, 3, 2, 1'b1);              // unfinished at end of text
        put_byte(8'h80, 1'b0);
        put_seq(21'h14E00, 4, 4, 1'b0);             // beyond 16 bits, low bits hit
        put_seq(21'h1FFFFF, 4, 4, 1'b1);            // largest code point, end on last byte
        wait_drained();

        // Same kind of text with initials only.
        write_mode(1'b1);
        put_seq(21'h5E8A, 3, 3, 1'b0);
        put_seq(21'h4E00, 3, 3, 1'b1);
        wait_drained();

        // Random text, slow receiver.
        write_mode(1'b0);
        queue_random_text(22);
        wait_drained();

        // Random text, slow sender, with a full drain in the middle.
        tx_idle_pct = 66;
        rx_idle_pct = 9;
        write_mode(1'b1);
        queue_random_text(11);
        wait_drained();
        queue_random_text(11);
        wait_drained();

        // Random text at full rate.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_mode(1'b0);
        queue_random_text(22);
        wait_drained();

        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/u2p_pkg.sv
hw/rtl/u2p_front.sv
hw/rtl/u2p_queue.sv
hw/rtl/u2p_back.sv
hw/rtl/utf8_to_pinyin_letters.sv
verif/tb_top.sv
